FILE: rtl/dtwl_pkg.sv
// Shared types and constants of the DDS tuning word serial loader.
package dtwl_pkg;

	localparam logic [1:0] KIND_CLOCK = 2'd0;
	localparam logic [1:0] KIND_LOAD  = 2'd1;
	localparam logic [1:0] KIND_DATA  = 2'd2;

	localparam int          FREQ_W    = 32;
	localparam int          REF_W     = 32;
	localparam int          TW_W      = 32;
	localparam int          STEP_W    = 6;
	localparam logic [5:0]  STEP_LAST = 6'd63;
	localparam logic [31:0] REF_RESET = 32'd125000000;

	typedef struct packed {
		logic       start;
		logic       div_step;
		logic       sym_load;
		logic       fs_load;
		logic [1:0] kind;
		logic       last;
	} dtwl_cmd_t;

endpackage

FILE: rtl/dtwl_dp.sv
// Datapath: reference register, restoring divider, frame shifter, output word register.
module dtwl_dp #(
	parameter int WORD_BITS    = 32,
	parameter int CONTROL_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dtwl_pkg::dtwl_cmd_t        cmd,
	input  logic                       cfg_we,
	input  logic [dtwl_pkg::REF_W-1:0] cfg_data,
	input  logic [dtwl_pkg::FREQ_W-1:0] freq_hz,
	output logic [1:0]                 symbol_kind,
	output logic                       data_bit,
	output logic [dtwl_pkg::TW_W-1:0]  tuning_word,
	output logic                       last
);

	localparam int FSW = WORD_BITS + CONTROL_BITS;

	logic [dtwl_pkg::REF_W-1:0]  ref_q;
	logic [dtwl_pkg::FREQ_W-1:0] fr_q;
	logic [dtwl_pkg::REF_W-1:0]  rem_q;
	logic [WORD_BITS-1:0]        quo_q;
	logic [FSW-1:0]              fs_q;
	logic [1:0]                  kind_q;
	logic                        bit_q;
	logic [dtwl_pkg::TW_W-1:0]   tw_q;
	logic                        last_q;

	logic [dtwl_pkg::REF_W:0]    shifted;
	logic [dtwl_pkg::REF_W+1:0]  diff;
	logic                        ge;
	logic [WORD_BITS+31:0]       quo_ext;
	logic [FSW-1:0]              fs_src;

	assign shifted = {rem_q, fr_q[dtwl_pkg::FREQ_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, ref_q};
	assign ge      = ~diff[dtwl_pkg::REF_W+1];
	assign quo_ext = {32'd0, quo_q};
	// frame word for the first data symbol comes from the fresh quotient
	assign fs_src  = cmd.fs_load ? FSW'(quo_q) : fs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= dtwl_pkg::REF_RESET;
		end else if (cfg_we) begin
			ref_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			fr_q  <= freq_hz;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			fr_q  <= {fr_q[dtwl_pkg::FREQ_W-2:0], 1'b0};
			rem_q <= ge ? diff[dtwl_pkg::REF_W-1:0] : shifted[dtwl_pkg::REF_W-1:0];
			quo_q <= {quo_q[WORD_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sym_load) begin
			kind_q <= cmd.kind;
			last_q <= cmd.last;
			tw_q   <= quo_ext[dtwl_pkg::TW_W-1:0];
			if (cmd.kind == dtwl_pkg::KIND_DATA) begin
				bit_q <= fs_src[0];
				fs_q  <= fs_src >> 1;
			end else begin
				bit_q <= 1'b0;
				fs_q  <= fs_src;
			end
		end
	end

	assign symbol_kind = kind_q;
	assign data_bit    = bit_q;
	assign tuning_word = tw_q;
	assign last        = last_q;

endmodule

FILE: rtl/dtwl_ctrl.sv
// Controller: sequences accept, divide steps and symbol emission.
module dtwl_ctrl #(
	parameter int WORD_BITS    = 32,
	parameter int CONTROL_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output dtwl_pkg::dtwl_cmd_t cmd
);

	localparam int NSYM = WORD_BITS + CONTROL_BITS + 3;
	localparam int SW   = $clog2(NSYM);
	localparam logic [SW-1:0] SYM_FIRST = SW'(0);
	localparam logic [SW-1:0] SYM_LOAD  = SW'(1);
	localparam logic [SW-1:0] SYM_LAST  = SW'(NSYM - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]                  state_q;
	logic [dtwl_pkg::STEP_W-1:0] step_q;
	logic [SW-1:0]               sym_q;
	logic                        out_valid_q;
	logic                        ld;
	logic                        sym_last;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign ld        = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign sym_last  = (sym_q == SYM_LAST);

	always_comb begin
		cmd          = '0;
		cmd.start    = in_valid && in_ready;
		cmd.div_step = (state_q == ST_DIV);
		cmd.sym_load = ld;
		cmd.fs_load  = (sym_q == SYM_FIRST);
		cmd.last     = sym_last;
		if (sym_q == SYM_FIRST) begin
			cmd.kind = dtwl_pkg::KIND_CLOCK;
		end else if (sym_q == SYM_LOAD || sym_last) begin
			cmd.kind = dtwl_pkg::KIND_LOAD;
		end else begin
			cmd.kind = dtwl_pkg::KIND_DATA;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			sym_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						step_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == dtwl_pkg::STEP_LAST) begin
						sym_q   <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (ld) begin
						sym_q <= sym_q + 1'b1;
						if (sym_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_accept_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_DIV && step_q == '0)
		else $error("accepted word did not start divide");
	a_div_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && step_q == dtwl_pkg::STEP_LAST |=> state_q == ST_EMIT && sym_q == '0)
		else $error("divide did not hand over to emission");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ld && sym_last |=> state_q == ST_IDLE && out_valid_q)
		else $error("frame end mishandled");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && out_valid_q && !out_ready |=> $stable(sym_q))
		else $error("symbol index moved under stall");

endmodule

FILE: rtl/dds_tuning_word_serial_loader.sv
// Top level of the DDS tuning word serial loader.
//
//  channel | signals                                    | accepted when
//  --------+--------------------------------------------+-------------------------
//  in      | in_valid, in_ready, freq_hz                | in_valid & in_ready
//  out     | out_valid, out_ready, symbol_kind,         | out_valid & out_ready
//          | data_bit, tuning_word, last                |
//  cfg     | cfg_valid, cfg_ready, cfg_data             | cfg_valid & cfg_ready
//
// One word goes through an accept, 64 restoring divide steps (one quotient bit per
// cycle in the shared subtractor) and WORD_BITS+CONTROL_BITS+3 symbols.
// The last symbol waits in the output register while the next divide runs.
// out_ready low freezes emission; the reference register resets to 125000000.
module dds_tuning_word_serial_loader #(
	parameter int WORD_BITS    = 32,
	parameter int CONTROL_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [dtwl_pkg::FREQ_W-1:0] freq_hz,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  symbol_kind,
	output logic                        data_bit,
	output logic [dtwl_pkg::TW_W-1:0]   tuning_word,
	output logic                        last,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [dtwl_pkg::REF_W-1:0]  cfg_data
);

	dtwl_pkg::dtwl_cmd_t cmd;

	assign cfg_ready = 1'b1;

	dtwl_ctrl #(
		.WORD_BITS    (WORD_BITS),
		.CONTROL_BITS (CONTROL_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	dtwl_dp #(
		.WORD_BITS    (WORD_BITS),
		.CONTROL_BITS (CONTROL_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.freq_hz     (freq_hz),
		.symbol_kind (symbol_kind),
		.data_bit    (data_bit),
		.tuning_word (tuning_word),
		.last        (last)
	);

endmodule
